// ----- hw/rtl/cfdlw_pkg.sv -----
// shared types and constants of the control frame deframer
`default_nettype none
package cfdlw_pkg;

    localparam int PAYLOAD_BYTES = 13;
    localparam int STORE_DEPTH   = PAYLOAD_BYTES - 1;
    localparam int IDX_W         = $clog2(PAYLOAD_BYTES);

    typedef enum logic [1:0] {
        CMD_BYTE = 2'd0,
        CMD_TICK = 2'd1,
        CMD_EOB  = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        LINK_DISC = 2'd0,
        LINK_CONN = 2'd1,
        LINK_ERR  = 2'd2
    } link_mode_t;

    typedef enum logic [1:0] {
        REG_SYNC_FIRST = 2'd0,
        REG_SYNC_SECOND = 2'd1,
        REG_TIMEOUT     = 2'd2
    } reg_index_t;

    localparam logic KIND_FRAME   = 1'b0;
    localparam logic KIND_LINK_ERR = 1'b1;

    // one accepted word as seen by the parser and the link watch
    typedef struct packed {
        logic       en;
        logic [1:0] cmd;
    } step_t;

    typedef struct packed {
        logic good;
        logic len_err;
    } parse_evt_t;

    typedef struct packed {
        logic signed [15:0] speed_x;
        logic signed [15:0] speed_y;
        logic signed [15:0] turn_rate;
        logic signed [15:0] joint_fore_aft;
        logic signed [15:0] joint_lift;
        logic signed [15:0] joint_flip;
        logic               grab_bit;
        logic               estop_bit;
    } frame_cmds_t;

endpackage
`default_nettype wire

// ----- hw/rtl/cfdlw_parser.sv -----
// sync hunt, length check and payload capture
`default_nettype none
module cfdlw_parser
    import cfdlw_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire step_t       step,
    input  wire logic [7:0]  data_byte,
    input  wire logic [7:0]  sync_first,
    input  wire logic [7:0]  sync_second,
    output parse_evt_t       evt,
    output frame_cmds_t      cmds
);

    typedef enum logic [1:0] {
        PH_SYNC1,
        PH_SYNC2,
        PH_LEN,
        PH_DATA
    } phase_t;

    phase_t            phase_reg, phase_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic              burst_done_reg, burst_done_next;
    logic              store_we;
    logic [7:0]        store_reg [STORE_DEPTH];

    always_comb begin
        phase_next      = phase_reg;
        idx_next        = idx_reg;
        burst_done_next = burst_done_reg;
        evt             = '0;
        store_we        = 1'b0;
        if (step.en) begin
            unique case (step.cmd)
                CMD_BYTE: begin
                    if (!burst_done_reg) begin
                        unique case (phase_reg)
                            PH_SYNC1: begin
                                if (data_byte == sync_first) phase_next = PH_SYNC2;
                            end
                            PH_SYNC2: begin
                                if (data_byte == sync_second) phase_next = PH_LEN;
                                else if (data_byte != sync_first) phase_next = PH_SYNC1;
                            end
                            PH_LEN: begin
                                if (data_byte == 8'(PAYLOAD_BYTES)) begin
                                    phase_next = PH_DATA;
                                    idx_next   = '0;
                                end else begin
                                    evt.len_err = 1'b1;
                                    // rescan from the second sync byte
                                    if (sync_first == sync_second && data_byte == sync_second)
                                        phase_next = PH_LEN;
                                    else if (data_byte == sync_first)
                                        phase_next = PH_SYNC2;
                                    else
                                        phase_next = PH_SYNC1;
                                end
                            end
                            PH_DATA: begin
                                if (idx_reg < IDX_W'(STORE_DEPTH)) begin
                                    store_we = 1'b1;
                                    idx_next = idx_reg + 1'b1;
                                end else begin
                                    evt.good        = 1'b1;
                                    burst_done_next = 1'b1;
                                    phase_next      = PH_SYNC1;
                                    idx_next        = '0;
                                end
                            end
                            default: phase_next = PH_SYNC1;
                        endcase
                    end
                end
                CMD_EOB: begin
                    phase_next      = PH_SYNC1;
                    idx_next        = '0;
                    burst_done_next = 1'b0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_SYNC1;
            idx_reg        <= '0;
            burst_done_reg <= 1'b0;
        end else begin
            phase_reg      <= phase_next;
            idx_reg        <= idx_next;
            burst_done_reg <= burst_done_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (store_we) store_reg[idx_reg] <= data_byte;
    end

    // big-endian byte pairs, last byte carries the flag bits
    assign cmds.speed_x        = signed'({store_reg[0], store_reg[1]});
    assign cmds.speed_y        = signed'({store_reg[2], store_reg[3]});
    assign cmds.turn_rate      = signed'({store_reg[4], store_reg[5]});
    assign cmds.joint_fore_aft = signed'({store_reg[6], store_reg[7]});
    assign cmds.joint_lift     = signed'({store_reg[8], store_reg[9]});
    assign cmds.joint_flip     = signed'({store_reg[10], store_reg[11]});
    assign cmds.grab_bit       = data_byte[0];
    assign cmds.estop_bit      = data_byte[1];

endmodule
`default_nettype wire

// ----- hw/rtl/cfdlw_link.sv -----
// link state, idle tick watch and event counters
`default_nettype none
module cfdlw_link
    import cfdlw_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire step_t       step,
    input  wire parse_evt_t  evt,
    input  wire logic [15:0] timeout_ticks,
    output logic             timeout_evt,
    output logic [1:0]       link_next,
    output logic [15:0]      good_next,
    output logic [15:0]      bad_next
);

    link_mode_t  link_reg, link_mode_next;
    logic [15:0] idle_reg, idle_next;
    logic [15:0] good_reg, bad_reg;

    always_comb begin
        link_mode_next = link_reg;
        idle_next      = idle_reg;
        good_next      = good_reg;
        bad_next       = bad_reg;
        timeout_evt    = 1'b0;
        if (evt.good) begin
            good_next      = good_reg + 16'd1;
            link_mode_next = LINK_CONN;
            idle_next      = '0;
        end
        if (evt.len_err) bad_next = bad_reg + 16'd1;
        if (step.en && step.cmd == CMD_TICK) begin
            if (idle_reg != 16'hFFFF) idle_next = idle_reg + 16'd1;
            if (link_reg == LINK_CONN && idle_next >= timeout_ticks) begin
                link_mode_next = LINK_ERR;
                bad_next       = bad_reg + 16'd1;
                timeout_evt    = 1'b1;
            end
        end
    end

    assign link_next = link_mode_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            link_reg <= LINK_DISC;
            idle_reg <= '0;
            good_reg <= '0;
            bad_reg  <= '0;
        end else begin
            link_reg <= link_mode_next;
            idle_reg <= idle_next;
            good_reg <= good_next;
            bad_reg  <= bad_next;
        end
    end

endmodule
`default_nettype wire

// ----- hw/rtl/control_frame_deframer_link_watch_top.sv -----
// Control frame deframer with link watch, top level.
//
// Input channel (s_valid/s_ready): one word per handshake, s_cmd selects a
// received byte (s_data_byte), a one millisecond tick or an end-of-burst mark.
// Result channel (m_valid/m_ready): a decoded frame (kind 0) or a link-error
// event (kind 1), with link state and wrapping good/bad counters.
// Configuration: cfg_wr_en writes cfg_data into register cfg_index
// (0 first sync byte, 1 second sync byte, 2 timeout in ticks) at once.
//
// Throughput is one word per cycle. Each word is handled by a single level of
// state-update logic; the result is in the output register the cycle after
// the word is taken. The output register frees as its result is taken, so
// s_ready stays high while m_ready is high; if the receiver stalls with a
// result waiting, s_ready drops until that result goes.
// Reset (aresetn low, synchronous) clears the hunt, the link to disconnected,
// the counters, the output valid and restores the register defaults.
`default_nettype none
module control_frame_deframer_link_watch_top
    import cfdlw_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_wr_en,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [15:0]        cfg_data,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [1:0]         s_cmd,
    input  wire logic [7:0]         s_data_byte,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic                    m_kind,
    output logic signed [15:0]      m_speed_x,
    output logic signed [15:0]      m_speed_y,
    output logic signed [15:0]      m_turn_rate,
    output logic signed [15:0]      m_joint_fore_aft,
    output logic signed [15:0]      m_joint_lift,
    output logic signed [15:0]      m_joint_flip,
    output logic                    m_grab_bit,
    output logic                    m_estop_bit,
    output logic [1:0]              m_link_state,
    output logic [15:0]             m_good_frames,
    output logic [15:0]             m_bad_events
);

    logic [7:0]   sync_first_reg, sync_second_reg;
    logic [15:0]  timeout_reg;
    step_t        step;
    parse_evt_t   evt;
    frame_cmds_t  cmds;
    logic         timeout_evt;
    logic [1:0]   link_next;
    logic [15:0]  good_next, bad_next;
    logic         m_valid_reg, m_valid_next;
    logic         load;

    logic         kind_reg;
    frame_cmds_t  cmds_reg;
    logic [1:0]   link_state_reg;
    logic [15:0]  good_reg, bad_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sync_first_reg  <= 8'd170;
            sync_second_reg <= 8'd85;
            timeout_reg     <= 16'd100;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_SYNC_FIRST:  sync_first_reg  <= cfg_data[7:0];
                REG_SYNC_SECOND: sync_second_reg <= cfg_data[7:0];
                REG_TIMEOUT:     timeout_reg     <= cfg_data;
                default: ;
            endcase
        end
    end

    assign s_ready  = !m_valid_reg || m_ready;
    assign step.en  = s_valid && s_ready;
    assign step.cmd = s_cmd;

    cfdlw_parser u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (step),
        .data_byte   (s_data_byte),
        .sync_first  (sync_first_reg),
        .sync_second (sync_second_reg),
        .evt         (evt),
        .cmds        (cmds)
    );

    cfdlw_link u_link (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .step          (step),
        .evt           (evt),
        .timeout_ticks (timeout_reg),
        .timeout_evt   (timeout_evt),
        .link_next     (link_next),
        .good_next     (good_next),
        .bad_next      (bad_next)
    );

    assign load = evt.good || timeout_evt;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (load) m_valid_next = 1'b1;
        else if (m_ready) m_valid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) m_valid_reg <= 1'b0;
        else          m_valid_reg <= m_valid_next;
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            kind_reg       <= timeout_evt ? KIND_LINK_ERR : KIND_FRAME;
            cmds_reg       <= evt.good ? cmds : '0;
            link_state_reg <= link_next;
            good_reg       <= good_next;
            bad_reg        <= bad_next;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_kind           = kind_reg;
    assign m_speed_x        = cmds_reg.speed_x;
    assign m_speed_y        = cmds_reg.speed_y;
    assign m_turn_rate      = cmds_reg.turn_rate;
    assign m_joint_fore_aft = cmds_reg.joint_fore_aft;
    assign m_joint_lift     = cmds_reg.joint_lift;
    assign m_joint_flip     = cmds_reg.joint_flip;
    assign m_grab_bit       = cmds_reg.grab_bit;
    assign m_estop_bit      = cmds_reg.estop_bit;
    assign m_link_state     = link_state_reg;
    assign m_good_frames    = good_reg;
    assign m_bad_events     = bad_reg;

endmodule
`default_nettype wire

// ----- hw/rtl/cfdlw_checker.sv -----
// port-level checks for the deframer top, bound onto it
`default_nettype none
module cfdlw_checker
    import cfdlw_pkg::*;
(
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               s_ready,
    input wire logic               m_valid,
    input wire logic               m_ready,
    input wire logic               m_kind,
    input wire logic signed [15:0] m_speed_x,
    input wire logic signed [15:0] m_speed_y,
    input wire logic signed [15:0] m_turn_rate,
    input wire logic signed [15:0] m_joint_fore_aft,
    input wire logic signed [15:0] m_joint_lift,
    input wire logic signed [15:0] m_joint_flip,
    input wire logic               m_grab_bit,
    input wire logic               m_estop_bit,
    input wire logic [1:0]         m_link_state,
    input wire logic [15:0]        m_bad_events
);

    // stalled result word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_kind) && $stable(m_speed_x)
            && $stable(m_link_state) && $stable(m_bad_events))
        else $error("stalled result changed");

    // link error words carry no commands
    a_err_word: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind |-> m_speed_x == 0 && m_speed_y == 0 && m_turn_rate == 0
            && m_joint_fore_aft == 0 && m_joint_lift == 0 && m_joint_flip == 0
            && !m_grab_bit && !m_estop_bit && m_link_state == LINK_ERR)
        else $error("link error word malformed");

    // a frame always leaves the link connected
    a_frame_conn: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_kind |-> m_link_state == LINK_CONN)
        else $error("frame word without connected link");

    // input only blocks behind a stalled result
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input stalled without cause");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind control_frame_deframer_link_watch_top cfdlw_checker u_cfdlw_checker (.*);
`default_nettype wire

// ----- tb/tb.sv -----
// testbench for the control frame deframer with link watch
`timescale 1ns / 1ps
module tb;
    import cfdlw_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 1_000_000;
    localparam logic [7:0]  FRAME_LEN   = 8'(PAYLOAD_BYTES);
    localparam logic [1:0]  CMD_UNUSED  = 2'd3;

    typedef enum int {
        HUNT_SYNC1,
        HUNT_SYNC2,
        HUNT_LEN,
        HUNT_DATA
    } hunt_t;

    typedef struct {
        logic        kind;
        frame_cmds_t cmds;
        link_mode_t  link;
        logic [15:0] good_frames;
        logic [15:0] bad_events;
    } deframe_out_t;

    typedef logic [7:0] frame_body_t [PAYLOAD_BYTES];

    class deframe_scoreboard;
        logic [7:0]   sync_a;
        logic [7:0]   sync_b;
        logic [15:0]  timeout;
        hunt_t        phase;
        int unsigned  idx;
        logic [7:0]   store [STORE_DEPTH];
        bit           burst_taken;
        link_mode_t   link;
        logic [15:0]  idle;
        logic [15:0]  good;
        logic [15:0]  bad;
        deframe_out_t expected [$];
        int unsigned  errors;

        function new();
            sync_a      = 8'd170;
            sync_b      = 8'd85;
            timeout     = 16'd100;
            phase       = HUNT_SYNC1;
            idx         = 0;
            burst_taken = 1'b0;
            link        = LINK_DISC;
            idle        = '0;
            good        = '0;
            bad         = '0;
            errors      = 0;
        endfunction

        function void set_reg(reg_index_t r, logic [15:0] d);
            case (r)
                REG_SYNC_FIRST: begin
                    sync_a = d[7:0];
                end
                REG_SYNC_SECOND: begin
                    sync_b = d[7:0];
                end
                REG_TIMEOUT: begin
                    timeout = d;
                end
                default: ;
            endcase
        endfunction

        function int unsigned pending();
            return expected.size();
        endfunction

        // advance the predicted state by one accepted word
        function void note_word(logic [1:0] c, logic [7:0] b);
            deframe_out_t r;
            r.cmds = '0;
            case (c)
                CMD_BYTE: begin
                    if (!burst_taken) begin
                        case (phase)
                            HUNT_SYNC1: begin
                                if (b == sync_a) phase = HUNT_SYNC2;
                            end
                            HUNT_SYNC2: begin
                                if (b == sync_b) phase = HUNT_LEN;
                                else if (b != sync_a) phase = HUNT_SYNC1;
                            end
                            HUNT_LEN: begin
                                if (b == FRAME_LEN) begin
                                    phase = HUNT_DATA;
                                    idx = 0;
                                end else begin
                                    bad++;
                                    // rescan from the second sync byte
                                    if (sync_a == sync_b && b == sync_b) phase = HUNT_LEN;
                                    else if (b == sync_a) phase = HUNT_SYNC2;
                                    else phase = HUNT_SYNC1;
                                end
                            end
                            default: begin
                                if (idx < STORE_DEPTH) begin
                                    store[idx] = b;
                                    idx++;
                                end else begin
                                    good++;
                                    link = LINK_CONN;
                                    idle = '0;
                                    burst_taken = 1'b1;
                                    phase = HUNT_SYNC1;
                                    idx = 0;
                                    r.kind = KIND_FRAME;
                                    r.cmds.speed_x = {store[0], store[1]};
                                    r.cmds.speed_y = {store[2], store[3]};
                                    r.cmds.turn_rate = {store[4], store[5]};
                                    r.cmds.joint_fore_aft = {store[6], store[7]};
                                    r.cmds.joint_lift = {store[8], store[9]};
                                    r.cmds.joint_flip = {store[10], store[11]};
                                    r.cmds.grab_bit = b[0];
                                    r.cmds.estop_bit = b[1];
                                    r.link = link;
                                    r.good_frames = good;
                                    r.bad_events = bad;
                                    expected.push_back(r);
                                end
                            end
                        endcase
                    end
                end
                CMD_TICK: begin
                    if (idle != 16'hFFFF) idle++;
                    if (link == LINK_CONN && idle >= timeout) begin
                        link = LINK_ERR;
                        bad++;
                        r.kind = KIND_LINK_ERR;
                        r.link = link;
                        r.good_frames = good;
                        r.bad_events = bad;
                        expected.push_back(r);
                    end
                end
                CMD_EOB: begin
                    phase = HUNT_SYNC1;
                    idx = 0;
                    burst_taken = 1'b0;
                end
                default: ;
            endcase
        endfunction

        function void match(string field, longint want, longint got);
            if (want != got) begin
                $error("%s: expected %0d, got %0d", field, want, got);
                errors++;
            end
        endfunction

        function void check_result(deframe_out_t got);
            deframe_out_t want;
            if (expected.size() == 0) begin
                $error("result with nothing pending: kind %0d", got.kind);
                errors++;
                return;
            end
            want = expected.pop_front();
            match("kind", want.kind, got.kind);
            match("speed_x", want.cmds.speed_x, got.cmds.speed_x);
            match("speed_y", want.cmds.speed_y, got.cmds.speed_y);
            match("turn_rate", want.cmds.turn_rate, got.cmds.turn_rate);
            match("joint_fore_aft", want.cmds.joint_fore_aft, got.cmds.joint_fore_aft);
            match("joint_lift", want.cmds.joint_lift, got.cmds.joint_lift);
            match("joint_flip", want.cmds.joint_flip, got.cmds.joint_flip);
            match("grab_bit", want.cmds.grab_bit, got.cmds.grab_bit);
            match("estop_bit", want.cmds.estop_bit, got.cmds.estop_bit);
            match("link_state", want.link, got.link);
            match("good_frames", want.good_frames, got.good_frames);
            match("bad_events", want.bad_events, got.bad_events);
        endfunction
    endclass

    logic               aclk        = 1'b0;
    logic               aresetn     = 1'b0;
    logic               cfg_wr_en   = 1'b0;
    logic [1:0]         cfg_index   = '0;
    logic [15:0]        cfg_data    = '0;
    logic               s_valid     = 1'b0;
    logic               s_ready;
    logic [1:0]         s_cmd       = '0;
    logic [7:0]         s_data_byte = '0;
    logic               m_valid;
    logic               m_ready     = 1'b0;
    logic               m_kind;
    logic signed [15:0] m_speed_x;
    logic signed [15:0] m_speed_y;
    logic signed [15:0] m_turn_rate;
    logic signed [15:0] m_joint_fore_aft;
    logic signed [15:0] m_joint_lift;
    logic signed [15:0] m_joint_flip;
    logic               m_grab_bit;
    logic               m_estop_bit;
    logic [1:0]         m_link_state;
    logic [15:0]        m_good_frames;
    logic [15:0]        m_bad_events;

    deframe_scoreboard sb;
    bit                send_rush   = 1'b0;
    bit                recv_rush   = 1'b0;
    int unsigned       words_sent  = 0;
    int unsigned       cycle_count = 0;
    int unsigned       ready_hold  = 0;

    control_frame_deframer_link_watch_top i_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_cmd            (s_cmd),
        .s_data_byte      (s_data_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_kind           (m_kind),
        .m_speed_x        (m_speed_x),
        .m_speed_y        (m_speed_y),
        .m_turn_rate      (m_turn_rate),
        .m_joint_fore_aft (m_joint_fore_aft),
        .m_joint_lift     (m_joint_lift),
        .m_joint_flip     (m_joint_flip),
        .m_grab_bit       (m_grab_bit),
        .m_estop_bit      (m_estop_bit),
        .m_link_state     (m_link_state),
        .m_good_frames    (m_good_frames),
        .m_bad_events     (m_bad_events)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // result side: hold ready low for a drawn number of cycles after each word
    always @(posedge aclk) begin : rx_pace
        int unsigned n;
        if (!aresetn) begin
            m_ready <= 1'b0;
            ready_hold <= 0;
        end else if (m_valid && m_ready) begin
            n = recv_rush ? 0 : $urandom_range(0, 8);
            if (n != 0) begin
                m_ready <= 1'b0;
                ready_hold <= n - 1;
            end
        end else if (!m_ready) begin
            if (ready_hold == 0) m_ready <= 1'b1;
            else ready_hold <= ready_hold - 1;
        end
    end

    // results are checked before the word taken on the same edge is noted
    always @(posedge aclk) begin : monitor
        deframe_out_t seen;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                seen.kind = m_kind;
                seen.cmds.speed_x = m_speed_x;
                seen.cmds.speed_y = m_speed_y;
                seen.cmds.turn_rate = m_turn_rate;
                seen.cmds.joint_fore_aft = m_joint_fore_aft;
                seen.cmds.joint_lift = m_joint_lift;
                seen.cmds.joint_flip = m_joint_flip;
                seen.cmds.grab_bit = m_grab_bit;
                seen.cmds.estop_bit = m_estop_bit;
                seen.link = link_mode_t'(m_link_state);
                seen.good_frames = m_good_frames;
                seen.bad_events = m_bad_events;
                sb.check_result(seen);
            end
            if (s_valid && s_ready) sb.note_word(s_cmd, s_data_byte);
        end
    end

    task automatic send_word(input logic [1:0] c, input logic [7:0] b);
        int unsigned gap;
        gap = send_rush ? 0 : $urandom_range(0, 8);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_cmd <= c;
        s_data_byte <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        words_sent++;
    endtask

    // a byte, now and then preceded by a tick or an unused command
    task automatic send_byte(input logic [7:0] b);
        case ($urandom_range(0, 19))
            0, 1: begin
                send_word(CMD_TICK, 8'($urandom_range(0, 255)));
            end
            2: begin
                send_word(CMD_UNUSED, 8'($urandom_range(0, 255)));
            end
            default: ;
        endcase
        send_word(CMD_BYTE, b);
    endtask

    task automatic send_frame(input frame_body_t body);
        send_word(CMD_BYTE, sb.sync_a);
        send_word(CMD_BYTE, sb.sync_b);
        send_word(CMD_BYTE, FRAME_LEN);
        for (int i = 0; i < PAYLOAD_BYTES; i++) send_word(CMD_BYTE, body[i]);
    endtask

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            2: return 8'h80;
            3: return 8'h7F;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // upper bits of the byte registers get noise
    task automatic apply_config(input logic [7:0] a, input logic [7:0] b,
                                input logic [15:0] t);
        logic [15:0] wa;
        logic [15:0] wb;
        wa = {8'($urandom_range(0, 255)), a};
        wb = {8'($urandom_range(0, 255)), b};
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_SYNC_FIRST;
        cfg_data <= wa;
        sb.set_reg(REG_SYNC_FIRST, wa);
        @(posedge aclk);
        cfg_index <= REG_SYNC_SECOND;
        cfg_data <= wb;
        sb.set_reg(REG_SYNC_SECOND, wb);
        @(posedge aclk);
        cfg_index <= REG_TIMEOUT;
        cfg_data <= t;
        sb.set_reg(REG_TIMEOUT, t);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic send_burst();
        int unsigned n;
        logic [7:0]  len;
        bit          cut;
        send_rush = ($urandom_range(0, 4) == 0);
        recv_rush = ($urandom_range(0, 4) == 0);
        if ($urandom_range(0, 5) == 0) begin
            repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
        end
        if ($urandom_range(0, 4) == 0) send_byte(sb.sync_a);
        send_byte(sb.sync_a);
        send_byte(sb.sync_b);
        len = ($urandom_range(0, 6) == 0) ? 8'($urandom_range(0, 255)) : FRAME_LEN;
        send_byte(len);
        cut = ($urandom_range(0, 9) == 0);
        n = cut ? $urandom_range(0, PAYLOAD_BYTES - 1) : PAYLOAD_BYTES;
        repeat (n) send_byte(pick_byte());
        if (!cut && $urandom_range(0, 3) == 0) begin
            // second frame in one burst
            send_byte(sb.sync_a);
            send_byte(sb.sync_b);
            send_byte(FRAME_LEN);
            repeat ($urandom_range(1, PAYLOAD_BYTES)) send_byte(pick_byte());
        end
        if ($urandom_range(0, 9) != 0) send_word(CMD_EOB, 8'($urandom_range(0, 255)));
    endtask

    task automatic run_phase(input logic [7:0] a, input logic [7:0] b,
                             input logic [15:0] t);
        int unsigned target;
        wait_idle();
        apply_config(a, b, t);
        target = words_sent + 190;
        while (words_sent < target) send_burst();
        send_rush = 1'b0;
        recv_rush = 1'b0;
    endtask

    initial begin
        frame_body_t body;
        sb = new();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // register defaults, extreme commands, both flag bits set
        body = '{8'h80, 8'h00, 8'h7F, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00,
                 8'h01, 8'h00, 8'hFE, 8'hFF, 8'h03};
        send_frame(body);
        send_word(CMD_BYTE, 8'hAA);
        send_word(CMD_UNUSED, 8'hFF);
        send_word(CMD_EOB, 8'h00);
        // repeated first sync, then a bad length
        send_word(CMD_BYTE, 8'hAA);
        send_word(CMD_BYTE, 8'hAA);
        send_word(CMD_BYTE, 8'h55);
        send_word(CMD_BYTE, 8'h07);
        // bad length equal to the first sync restarts at the second sync
        send_word(CMD_BYTE, 8'hAA);
        send_word(CMD_BYTE, 8'h55);
        send_word(CMD_BYTE, 8'hAA);
        send_word(CMD_BYTE, 8'h55);
        send_word(CMD_BYTE, FRAME_LEN);
        send_word(CMD_EOB, 8'hFF);
        send_word(CMD_TICK, 8'h5A);

        // shortest timeout trips on the next tick
        wait_idle();
        apply_config(8'hAA, 8'h55, 16'd1);
        send_word(CMD_TICK, 8'h00);
        send_word(CMD_TICK, 8'hFF);

        run_phase(8'hAA, 8'h55, 16'd3);
        run_phase(8'h00, 8'hFF, 16'd1);
        run_phase(8'hFF, 8'h00, 16'd65535);
        run_phase(8'h5A, 8'h5A, 16'd2);
        run_phase(FRAME_LEN, FRAME_LEN, 16'd4);
        run_phase(FRAME_LEN, 8'h77, 16'd6);
        run_phase(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  16'($urandom_range(1, 40)));
        run_phase(8'hAA, 8'h55, 16'd100);

        // longest timeout, ticks back to back
        wait_idle();
        apply_config(8'hAA, 8'h55, 16'd65535);
        foreach (body[i]) body[i] = pick_byte();
        send_frame(body);
        send_word(CMD_EOB, 8'h00);
        send_rush = 1'b1;
        recv_rush = 1'b1;
        repeat (16) send_word(CMD_TICK, 8'($urandom_range(0, 255)));

        // equal zero syncs: every further zero is a bad length
        wait_idle();
        apply_config(8'h00, 8'h00, 16'd65535);
        send_word(CMD_EOB, 8'h00);
        repeat (16) send_word(CMD_BYTE, 8'h00);
        send_word(CMD_EOB, 8'h00);
        foreach (body[i]) body[i] = pick_byte();
        send_frame(body);
        send_word(CMD_EOB, 8'h00);
        send_rush = 1'b0;
        recv_rush = 1'b0;

        wait_idle();
        repeat (10) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
